// ===== sv/assert_macros.svh =====
// Assertion helpers; they assume a clock named clock and a reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PDAL_ASSERT_NOW(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("assertion failed");
`define PDAL_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define PDAL_ASSERT_NOW(lbl, a, c)
`define PDAL_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ===== sv/pdal_pkg.sv =====
`default_nettype none
package pdal_pkg;

   localparam int LIGHT_W = 36;   // light held as Q20.16
   localparam int X_W     = 20;   // exp argument, Q.16, saturated
   localparam int Y_W     = 17;   // exp result, Q1.16
   localparam int DVD_W   = 60;
   localparam int DSR_W   = 36;
   localparam int EXP_WHOLE_LIMIT = 12;
   localparam int EXP_TERMS       = 12;

   localparam logic [63:0] EXP_NEG_ONE_Q32 = 64'd1580030169;

   localparam logic [23:0] PMAX_RESET  = 24'd65536;
   localparam logic [23:0] BETA_RESET  = 24'd0;
   localparam logic [23:0] SLOPE_RESET = 24'd1048576;
   localparam logic [8:0]  STEPS_RESET = 9'd10;

   typedef logic [32:0] exp_tab_type [EXP_WHOLE_LIMIT];

   // e^-m in Q1.32, built by repeated rounded multiplies
   function automatic exp_tab_type exp_tab_build();
      exp_tab_type t;
      logic [63:0] e;
      e = 64'h1_0000_0000;
      for (int m = 0; m < EXP_WHOLE_LIMIT; m++) begin
         t[m] = e[32:0];
         e = (e * EXP_NEG_ONE_Q32 + 64'h8000_0000) >> 32;
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_INT_TAB = exp_tab_build();

   // ceil(2^36 / k); floor(p*R >> 36) equals p / k for any p below 2^32
   typedef logic [36:0] rcp_tab_type [EXP_TERMS + 1];

   function automatic rcp_tab_type rcp_tab_build();
      rcp_tab_type t;
      t[0] = '0;
      for (int k = 1; k <= EXP_TERMS; k++)
         t[k] = 37'(((64'd1 << 36) + 64'(k) - 64'd1) / 64'(k));
      return t;
   endfunction

   localparam rcp_tab_type RCP_TAB = rcp_tab_build();

   typedef enum logic [1:0] {CSR_PMAX, CSR_BETA, CSR_SLOPE, CSR_STEPS} csr_index_type;

   typedef enum logic [1:0] {DIV_ATT, DIV_GROW, DIV_INHIB, DIV_FINAL} div_sel_type;

   typedef enum logic [2:0] {EXP_IDLE, EXP_MUL, EXP_DIV, EXP_ACC, EXP_FIN} exp_state_type;

   typedef enum logic [4:0] {
      C_IDLE, C_CHECK, C_ATT_DIV, C_ATT_WAIT, C_ATT_EXP, C_ATT_EWAIT,
      C_GROW_DIV, C_GROW_WAIT, C_INHIB_DIV, C_INHIB_WAIT, C_EXP, C_EXP_WAIT,
      C_TERM, C_ACC, C_FIN_DIV, C_FIN_WAIT, C_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        att_x_store;
      logic        att_exp_store;
      logic        grow_store;
      logic        inhib_store;
      logic        exp_att_start;
      logic        exp_pair_start;
      logic        term_store;
      logic        accum;
   } pdal_cmd_type;

   typedef struct packed {
      logic zero_case;
      logic div_done;
      logic expa_done;
      logic pair_done;
      logic last_step;
   } pdal_status_type;

endpackage
`default_nettype wire

// ===== sv/pdal_exp.sv =====
`default_nettype none
module pdal_exp import pdal_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [X_W-1:0] x,
   output logic           done,
   output logic [Y_W-1:0] y
);

   exp_state_type state_ff, state_in;
   logic [32:0] e_ff, e_in;
   logic [15:0] frac_ff, frac_in;
   logic [32:0] t_ff, t_in;          // current series term
   logic [32:0] p_ff, p_in;          // term times frac, before the divide by k
   logic [50:0] lo_ff, lo_in;        // low partial product of the reciprocal multiply
   logic        ph_ff, ph_in;
   logic [3:0]  k_ff, k_in;
   logic [33:0] plus_ff, plus_in;
   logic [32:0] minus_ff, minus_in;
   logic        done_ff, done_in;
   logic [Y_W-1:0] y_ff, y_in;

   logic [48:0] prod;
   logic [36:0] rcp;
   logic [50:0] lo_prod;
   logic [51:0] hi_prod;
   logic [69:0] qsum;
   logic [33:0] diff;
   logic [50:0] fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EXP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      e_ff     <= e_in;
      frac_ff  <= frac_in;
      t_ff     <= t_in;
      p_ff     <= p_in;
      lo_ff    <= lo_in;
      ph_ff    <= ph_in;
      k_ff     <= k_in;
      plus_ff  <= plus_in;
      minus_ff <= minus_in;
      y_ff     <= y_in;
   end

   always_comb begin
      prod    = t_ff * frac_ff;
      // divide by k as a multiply by its reciprocal, split into low and high partial products
      rcp     = RCP_TAB[k_ff];
      lo_prod = p_ff * rcp[17:0];
      hi_prod = p_ff * rcp[36:18];
      qsum    = {hi_prod, 18'b0} + 70'(lo_ff);
      diff    = plus_ff - {1'b0, minus_ff};
      fin     = e_ff[32:8] * diff[33:8] + 51'h8000_0000;

      state_in = state_ff;
      e_in     = e_ff;
      frac_in  = frac_ff;
      t_in     = t_ff;
      p_in     = p_ff;
      lo_in    = lo_ff;
      ph_in    = ph_ff;
      k_in     = k_ff;
      plus_in  = plus_ff;
      minus_in = minus_ff;
      done_in  = done_ff;
      y_in     = y_ff;

      unique case (state_ff)
         EXP_IDLE: begin
            if (start) begin
               done_in = 1'b0;
               if (32'(x[X_W-1:16]) >= EXP_WHOLE_LIMIT) begin
                  y_in    = '0;
                  done_in = 1'b1;
               end else begin
                  e_in     = EXP_INT_TAB[x[X_W-1:16]];
                  frac_in  = x[15:0];
                  t_in     = 33'h1_0000_0000;
                  plus_in  = 34'h1_0000_0000;
                  minus_in = '0;
                  k_in     = 4'd1;
                  state_in = EXP_MUL;
               end
            end
         end
         EXP_MUL: begin
            p_in     = prod[48:16];
            ph_in    = 1'b0;
            state_in = EXP_DIV;
         end
         EXP_DIV: begin
            if (!ph_ff) begin
               lo_in = lo_prod;
               ph_in = 1'b1;
            end else begin
               t_in     = qsum[68:36];
               state_in = EXP_ACC;
            end
         end
         EXP_ACC: begin
            if (k_ff[0]) minus_in = minus_ff + t_ff;
            else         plus_in  = plus_ff + {1'b0, t_ff};
            if (32'(k_ff) == EXP_TERMS) begin
               state_in = EXP_FIN;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = EXP_MUL;
            end
         end
         EXP_FIN: begin
            y_in     = fin[48:32];
            done_in  = 1'b1;
            state_in = EXP_IDLE;
         end
         default: state_in = EXP_IDLE;
      endcase
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule
`default_nettype wire

// ===== sv/pdal_div.sv =====
`default_nettype none
module pdal_div import pdal_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [X_W-1:0]   quo
);

   localparam int CW = $clog2(X_W);
   localparam int TW = DVD_W - X_W;

   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [X_W-1:0]   q_ff, q_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             chk_ff, chk_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [DSR_W:0] r2;
   logic [DSR_W:0] r2_sub;
   logic           ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff  <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         chk_ff  <= chk_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      r2     = {rem_ff, dvd_ff[X_W-1]};
      ge     = r2 >= {1'b0, dsr_ff};
      r2_sub = r2 - {1'b0, dsr_ff};

      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      chk_in  = 1'b0;
      run_in  = run_ff;
      done_in = done_ff;

      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         chk_in  = 1'b1;
         run_in  = 1'b0;
         done_in = 1'b0;
      end else if (chk_ff) begin
         // quotient too big for X_W bits: saturate
         if (dvd_ff[DVD_W-1:X_W] >= {{(TW-DSR_W){1'b0}}, dsr_ff}) begin
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            rem_in = dvd_ff[X_W+DSR_W-1:X_W];
            cnt_in = '0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         rem_in = ge ? r2_sub[DSR_W-1:0] : r2[DSR_W-1:0];
         q_in   = {q_ff[X_W-2:0], ge};
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(X_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule
`default_nettype wire

// ===== sv/pdal_dpath.sv =====
`default_nettype none
module pdal_dpath import pdal_pkg::*; #(
   parameter int MAX_STEPS = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  pdal_cmd_type    cmd,
   output pdal_status_type st,
   input  logic [19:0]     req_light_top,
   input  logic [15:0]     req_extinction,
   input  logic [15:0]     req_layer_depth,
   input  logic [23:0]     pmax,
   input  logic [23:0]     inhibition_beta,
   input  logic [23:0]     initial_slope,
   input  logic [8:0]      step_count,
   output logic [Y_W-1:0]  rsp_light_limitation
);

   localparam int NW = $clog2(MAX_STEPS + 1);
   localparam int SW = 32 + NW;

   logic [LIGHT_W-1:0] light_ff, light_in;
   logic [15:0]        kext_ff, depth_ff;
   logic [NW-1:0]      n_ff, step_ff;
   logic [SW-1:0]      sum_ff;
   logic [X_W-1:0]     xatt_ff, xg_ff, xi_ff;
   logic [Y_W-1:0]     atten_ff;
   logic [32:0]        term_ff;
   logic               zero_ff;

   logic [NW-1:0]      n_c;
   logic [31:0]        kd;
   logic [23:0]        coef;
   logic [DVD_W-1:0]   cl_prod;
   logic [SW:0]        fsum;
   logic [DVD_W-1:0]   dvd_mux;
   logic [DSR_W-1:0]   dsr_mux;
   logic [52:0]        lprod;
   logic [33:0]        tprod;

   logic               div_done, a_done, b_done;
   logic [X_W-1:0]     quo;
   logic [X_W-1:0]     xa;
   logic [Y_W-1:0]     ya, yb;

   always_comb begin
      if (step_count == 9'd0)                  n_c = NW'(1);
      else if (int'(step_count) > MAX_STEPS)   n_c = NW'(MAX_STEPS);
      else                                     n_c = NW'(step_count);
   end

   always_comb begin
      kd      = kext_ff * depth_ff;
      coef    = (cmd.div_sel == DIV_INHIB) ? inhibition_beta : initial_slope;
      cl_prod = coef * light_ff;
      fsum    = {1'b0, sum_ff} + (SW+1)'({n_ff, 15'b0});
      unique case (cmd.div_sel)
         DIV_ATT: begin
            dvd_mux = DVD_W'(kd);
            dsr_mux = DSR_W'({n_ff, 4'b0});
         end
         DIV_GROW, DIV_INHIB: begin
            dvd_mux = cl_prod;
            dsr_mux = {pmax, 12'b0};
         end
         DIV_FINAL: begin
            dvd_mux = DVD_W'(fsum);
            dsr_mux = DSR_W'({n_ff, 16'b0});
         end
         default: begin
            dvd_mux = '0;
            dsr_mux = '0;
         end
      endcase
      lprod    = light_ff * atten_ff + 53'd32768;
      tprod    = (17'd65536 - ya) * yb;
      light_in = lprod[LIGHT_W+15:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         light_ff <= {req_light_top, 16'b0};
         kext_ff  <= req_extinction;
         depth_ff <= req_layer_depth;
         n_ff     <= n_c;
         step_ff  <= '0;
         sum_ff   <= '0;
         // judged on the request's depth and light and on pmax; any of them zero gives a zero result
         zero_ff  <= (req_layer_depth == 16'd0) || (req_light_top == 20'd0) ||
                     (pmax == 24'd0);
      end
      if (cmd.att_x_store)   xatt_ff  <= quo;
      if (cmd.grow_store)    xg_ff    <= quo;
      if (cmd.inhib_store)   xi_ff    <= quo;
      if (cmd.att_exp_store) atten_ff <= ya;
      if (cmd.term_store)    term_ff  <= tprod[32:0];
      if (cmd.accum) begin
         sum_ff   <= sum_ff + SW'(term_ff);
         light_ff <= light_in;
         step_ff  <= step_ff + NW'(1);
      end
   end

   assign xa = cmd.exp_att_start ? xatt_ff : xg_ff;

   pdal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd_mux),
      .divisor  (dsr_mux),
      .done     (div_done),
      .quo      (quo)
   );

   pdal_exp u_exp_a (
      .clock (clock),
      .reset (reset),
      .start (cmd.exp_att_start | cmd.exp_pair_start),
      .x     (xa),
      .done  (a_done),
      .y     (ya)
   );

   pdal_exp u_exp_b (
      .clock (clock),
      .reset (reset),
      .start (cmd.exp_pair_start),
      .x     (xi_ff),
      .done  (b_done),
      .y     (yb)
   );

   assign st.zero_case = zero_ff;
   assign st.div_done  = div_done;
   assign st.expa_done = a_done;
   assign st.pair_done = a_done & b_done;
   assign st.last_step = (step_ff == n_ff - NW'(1));

   assign rsp_light_limitation = st.zero_case ? '0 : quo[Y_W-1:0];

endmodule
`default_nettype wire

// ===== sv/pdal_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module pdal_ctrl import pdal_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  pdal_status_type st,
   output pdal_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_strobe
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= C_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_ATT;
      unique case (state_ff)
         C_IDLE: if (start) begin
            cmd.load = 1'b1;
            state_in = C_CHECK;
         end
         C_CHECK:     state_in = st.zero_case ? C_OUT : C_ATT_DIV;
         C_ATT_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ATT;
            state_in      = C_ATT_WAIT;
         end
         C_ATT_WAIT: if (st.div_done) begin
            cmd.att_x_store = 1'b1;
            state_in        = C_ATT_EXP;
         end
         C_ATT_EXP: begin
            cmd.exp_att_start = 1'b1;
            state_in          = C_ATT_EWAIT;
         end
         C_ATT_EWAIT: if (st.expa_done) begin
            cmd.att_exp_store = 1'b1;
            state_in          = C_GROW_DIV;
         end
         C_GROW_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_GROW;
            state_in      = C_GROW_WAIT;
         end
         C_GROW_WAIT: if (st.div_done) begin
            cmd.grow_store = 1'b1;
            state_in       = C_INHIB_DIV;
         end
         C_INHIB_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_INHIB;
            state_in      = C_INHIB_WAIT;
         end
         C_INHIB_WAIT: if (st.div_done) begin
            cmd.inhib_store = 1'b1;
            state_in        = C_EXP;
         end
         C_EXP: begin
            cmd.exp_pair_start = 1'b1;
            state_in           = C_EXP_WAIT;
         end
         C_EXP_WAIT:  if (st.pair_done) state_in = C_TERM;
         C_TERM: begin
            cmd.term_store = 1'b1;
            state_in       = C_ACC;
         end
         C_ACC: begin
            cmd.accum = 1'b1;
            state_in  = st.last_step ? C_FIN_DIV : C_GROW_DIV;
         end
         C_FIN_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FINAL;
            state_in      = C_FIN_WAIT;
         end
         C_FIN_WAIT:  if (st.div_done) state_in = C_OUT;
         C_OUT:       state_in = C_IDLE;
         default:     state_in = C_IDLE;
      endcase
   end

   assign busy       = (state_ff != C_IDLE);
   assign rsp_strobe = (state_ff == C_OUT);

   `PDAL_ASSERT_NEXT(a_accept_busy, start && !busy, state_ff == C_CHECK)
   `PDAL_ASSERT_NEXT(a_strobe_idle, rsp_strobe, !busy && !rsp_strobe)
   `PDAL_ASSERT_NEXT(a_div_restart, cmd.div_start, !st.div_done)
   `PDAL_ASSERT_NOW(a_term_ready, cmd.term_store, st.pair_done)

endmodule
`default_nettype wire

// ===== sv/platt_depth_avg_light_limitation.sv =====
// Depth-averaged Platt light limitation. A request is taken when start is high and busy is
// low; the result appears on rsp_light_limitation for exactly one cycle with rsp_strobe and
// must be captured then, since the receiver cannot stall the block. One request is worked
// at a time. Zero depth, light or pmax goes from the check state straight to the output
// state and strobes a zero result. Otherwise, for n Euler steps, every step runs two
// divisions on the shared 20-bit restoring divider, then both exp units in parallel (12
// series terms, each a multiply, a reciprocal multiply for the divide by k split into low
// and high partial products, and an accumulate), then the term and accumulate states; the
// attenuation divide and exp come before the steps and the final divide after them.
// Saturated arguments finish sooner. busy drops in the cycle after the strobe.
`default_nettype none
module platt_depth_avg_light_limitation import pdal_pkg::*; #(
   parameter int MAX_STEPS = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [19:0]     req_light_top,
   input  logic [15:0]     req_extinction,
   input  logic [15:0]     req_layer_depth,
   output logic            rsp_strobe,
   output logic [16:0]     rsp_light_limitation,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [23:0]     csr_data
);

   logic [23:0] pmax_ff, beta_ff, slope_ff;
   logic [8:0]  steps_ff;

   pdal_cmd_type    cmd;
   pdal_status_type st;

   always_ff @(posedge clock) begin
      if (reset) begin
         pmax_ff  <= PMAX_RESET;
         beta_ff  <= BETA_RESET;
         slope_ff <= SLOPE_RESET;
         steps_ff <= STEPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PMAX:  pmax_ff  <= csr_data;
            CSR_BETA:  beta_ff  <= csr_data;
            CSR_SLOPE: slope_ff <= csr_data;
            CSR_STEPS: steps_ff <= csr_data[8:0];
            default:   ;
         endcase
      end
   end

   pdal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .st         (st),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pdal_dpath #(.MAX_STEPS(MAX_STEPS)) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .req_light_top        (req_light_top),
      .req_extinction       (req_extinction),
      .req_layer_depth      (req_layer_depth),
      .pmax                 (pmax_ff),
      .inhibition_beta      (beta_ff),
      .initial_slope        (slope_ff),
      .step_count           (steps_ff),
      .rsp_light_limitation (rsp_light_limitation)
   );

endmodule
`default_nettype wire
